@@ design/ngga_pkg.sv @@
// ngga_pkg: shared types and character codes of the GGA position parser
// used by the parser, the conversion pipeline, the top level and the checker
// no dependencies

package ngga_pkg;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SIX    = 8'h36;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_W      = 8'h57;

  // digit limits of the number fields
  localparam logic [2:0] LAT_INT_DIGITS = 3'd4;
  localparam logic [2:0] LON_INT_DIGITS = 3'd5;
  localparam logic [2:0] FRAC_DIGITS    = 3'd5;

  // upper bound on the billionths value a result can carry
  localparam logic [30:0] BILL_MAX = 31'd1666666650;

  // position in raw form: integer part, fraction scaled to five digits, hemisphere
  typedef struct packed {
    logic [13:0] lat_ipart;
    logic [16:0] lat_f5;
    logic [7:0]  lat_hemi;
    logic [16:0] lon_ipart;
    logic [16:0] lon_f5;
    logic [7:0]  lon_hemi;
  } pos_raw_t;

  // one fix event handed from the parser to the conversion pipeline
  typedef struct packed {
    logic       fix_valid;
    logic [7:0] fix_quality;
    pos_raw_t   pos;
  } raw_fix_t;

  // one finished result beat
  typedef struct packed {
    logic        fix_valid;
    logic [7:0]  fix_quality;
    logic [6:0]  lat_degrees;
    logic [30:0] lat_billionths;
    logic [7:0]  lat_hemisphere;
    logic [9:0]  lon_degrees;
    logic [30:0] lon_billionths;
    logic [7:0]  lon_hemisphere;
  } result_t;

endpackage

@@ design/nmea_gga_position_parser_unit.sv @@
// NMEA GGA position parser: one character beat in, one position beat per GGA fix
// The input channel (in_valid, in_stall, in_ch) carries one ASCII character per beat.
// The parser hunts for the tag GGA, skips the time field, collects latitude,
// N/S, longitude and E/W, and on the fix-quality character emits one result beat
// on the output channel (out_valid, out_stall, out_* fields). A fix of quality
// '1', '2' or '6' with an E or W field updates the held position; every result
// reports the held position, zero until the first valid fix.
// Throughput: one character per cycle while in_stall is low. The parser state
// machine takes a character in the cycle it arrives; results go through a
// six-stage conversion pipeline (capture, divide by 100, minutes, scaling,
// divide by 3 by reciprocal multiply, final sum). When the receiver stalls,
// results queue in the pipeline stages; up to six results can wait, and
// in_stall rises only once all six stages are full.
// Reset (rst_n low, synchronous): the parser returns to the hunt, positions clear
// to zero and the pipeline empties.
// Depends on ngga_pkg, ngga_parser and ngga_conv_pipe.

module nmea_gga_position_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fix_valid,
  output logic [7:0]  out_fix_quality,
  output logic [6:0]  out_lat_degrees,
  output logic [30:0] out_lat_billionths,
  output logic [7:0]  out_lat_hemisphere,
  output logic [9:0]  out_lon_degrees,
  output logic [30:0] out_lon_billionths,
  output logic [7:0]  out_lon_hemisphere
);

  logic               pipe_ready;
  logic               accept;
  logic               fire;
  ngga_pkg::raw_fix_t fix;
  ngga_pkg::result_t  res;

  // input handshake
  assign in_stall = !pipe_ready;
  assign accept   = in_valid && pipe_ready;

  // character state machine
  ngga_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_ch),
    .fire   (fire),
    .fix    (fix)
  );

  // position conversion pipeline
  ngga_conv_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (fire),
    .in_fix    (fix),
    .in_ready  (pipe_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  // result fields
  assign out_fix_valid      = res.fix_valid;
  assign out_fix_quality    = res.fix_quality;
  assign out_lat_degrees    = res.lat_degrees;
  assign out_lat_billionths = res.lat_billionths;
  assign out_lat_hemisphere = res.lat_hemisphere;
  assign out_lon_degrees    = res.lon_degrees;
  assign out_lon_billionths = res.lon_billionths;
  assign out_lon_hemisphere = res.lon_hemisphere;

endmodule

@@ design/ngga_parser.sv @@
// ngga_parser: character state machine of the GGA sentence parser
// keeps the working and held positions in raw form and flags fix events
// depends on ngga_pkg

module ngga_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        ch,
  output logic              fire,
  output ngga_pkg::raw_fix_t fix
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEAD,
    PH_TIME,
    PH_LAT,
    PH_NS,
    PH_LON,
    PH_EW,
    PH_FIX
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         tag_r, tag_nxt;
  logic [16:0]        iacc_r, iacc_nxt;
  logic [16:0]        facc_r, facc_nxt;
  logic [2:0]         fcnt_r, fcnt_nxt;
  logic [2:0]         icnt_r, icnt_nxt;
  logic               point_r, point_nxt;
  logic [7:0]         prev_r, prev_nxt;
  ngga_pkg::pos_raw_t work_r, work_nxt;
  ngga_pkg::pos_raw_t held_r, held_nxt;

  logic               is_digit;
  logic [3:0]         digit;
  logic [2:0]         int_max;
  logic [16:0]        f5;
  logic               quality_ok;
  logic               fix_ok;

  // fraction scaled up to exactly five digits; the accumulator has at most cnt digits
  function automatic logic [16:0] scale_frac(input logic [16:0] f, input logic [2:0] cnt);
    logic [16:0] r;
    unique case (cnt)
      3'd0:    r = '0;
      3'd1:    r = 17'(f * 17'd10000);
      3'd2:    r = 17'(f * 17'd1000);
      3'd3:    r = 17'(f * 17'd100);
      3'd4:    r = 17'(f * 17'd10);
      default: r = f;
    endcase
    return r;
  endfunction

  // character classes
  assign is_digit   = (ch >= ngga_pkg::CH_ZERO) && (ch <= ngga_pkg::CH_NINE);
  assign digit      = 4'(ch - ngga_pkg::CH_ZERO);
  assign int_max    = (phase_r == PH_LAT) ? ngga_pkg::LAT_INT_DIGITS
                                          : ngga_pkg::LON_INT_DIGITS;
  assign f5         = scale_frac(facc_r, fcnt_r);
  assign quality_ok = (ch == ngga_pkg::CH_ONE) || (ch == ngga_pkg::CH_TWO) ||
                      (ch == ngga_pkg::CH_SIX);
  assign fix_ok     = quality_ok && point_r;

  // next state of the parser for one accepted beat
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    iacc_nxt  = iacc_r;
    facc_nxt  = facc_r;
    fcnt_nxt  = fcnt_r;
    icnt_nxt  = icnt_r;
    point_nxt = point_r;
    prev_nxt  = prev_r;
    work_nxt  = work_r;
    held_nxt  = held_r;
    fire      = 1'b0;
    if (accept) begin
      prev_nxt = ch;
      if (ch == ngga_pkg::CH_DOLLAR) begin
        // restart the hunt from any phase
        phase_nxt = PH_HUNT;
        tag_nxt   = '0;
        iacc_nxt  = '0;
        facc_nxt  = '0;
        fcnt_nxt  = '0;
        icnt_nxt  = '0;
        point_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (ch == ngga_pkg::CH_G) begin
              tag_nxt = (tag_r != 2'd0) ? 2'd2 : 2'd1;
            end else if (ch == ngga_pkg::CH_A && tag_r == 2'd2) begin
              tag_nxt   = '0;
              phase_nxt = PH_HEAD;
            end else begin
              tag_nxt = '0;
            end
          end
          PH_HEAD: begin
            if (ch == ngga_pkg::CH_COMMA) phase_nxt = PH_TIME;
          end
          PH_TIME: begin
            if (ch == ngga_pkg::CH_COMMA) begin
              iacc_nxt  = '0;
              facc_nxt  = '0;
              fcnt_nxt  = '0;
              icnt_nxt  = '0;
              point_nxt = 1'b0;
              phase_nxt = PH_LAT;
            end
          end
          PH_LAT, PH_LON: begin
            if (ch == ngga_pkg::CH_COMMA) begin
              if (phase_r == PH_LAT) begin
                work_nxt.lat_ipart = iacc_r[13:0];
                work_nxt.lat_f5    = f5;
                phase_nxt          = PH_NS;
              end else begin
                work_nxt.lon_ipart = iacc_r;
                work_nxt.lon_f5    = f5;
                phase_nxt          = PH_EW;
              end
              iacc_nxt  = '0;
              facc_nxt  = '0;
              fcnt_nxt  = '0;
              icnt_nxt  = '0;
              point_nxt = 1'b0;
            end else if (ch == ngga_pkg::CH_POINT) begin
              point_nxt = 1'b1;
            end else if (is_digit) begin
              if (!point_r) begin
                if (icnt_r < int_max) begin
                  iacc_nxt = 17'(iacc_r * 17'd10 + 17'(digit));
                  icnt_nxt = icnt_r + 3'd1;
                end
              end else if (fcnt_r < ngga_pkg::FRAC_DIGITS) begin
                facc_nxt = 17'(facc_r * 17'd10 + 17'(digit));
                fcnt_nxt = fcnt_r + 3'd1;
              end
            end
          end
          PH_NS: begin
            if (prev_r == ngga_pkg::CH_COMMA) work_nxt.lat_hemi = ch;
            if (ch == ngga_pkg::CH_COMMA) begin
              iacc_nxt  = '0;
              facc_nxt  = '0;
              fcnt_nxt  = '0;
              icnt_nxt  = '0;
              point_nxt = 1'b0;
              phase_nxt = PH_LON;
            end
          end
          PH_EW: begin
            if (prev_r == ngga_pkg::CH_COMMA) work_nxt.lon_hemi = ch;
            // point flag is reused to remember the e/w check
            if (ch == ngga_pkg::CH_COMMA) begin
              point_nxt = (prev_r == ngga_pkg::CH_E) || (prev_r == ngga_pkg::CH_W);
              phase_nxt = PH_FIX;
            end
          end
          PH_FIX: begin
            if (fix_ok) held_nxt = work_r;
            fire      = 1'b1;
            iacc_nxt  = '0;
            facc_nxt  = '0;
            fcnt_nxt  = '0;
            icnt_nxt  = '0;
            point_nxt = 1'b0;
            tag_nxt   = '0;
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  // fix event payload: the held position as it stands after this beat
  always_comb begin
    fix.fix_valid   = fix_ok;
    fix.fix_quality = ch;
    fix.pos         = held_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      tag_r   <= '0;
      iacc_r  <= '0;
      facc_r  <= '0;
      fcnt_r  <= '0;
      icnt_r  <= '0;
      point_r <= 1'b0;
      prev_r  <= '0;
      work_r  <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      iacc_r  <= iacc_nxt;
      facc_r  <= facc_nxt;
      fcnt_r  <= fcnt_nxt;
      icnt_r  <= icnt_nxt;
      point_r <= point_nxt;
      prev_r  <= prev_nxt;
      work_r  <= work_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

@@ design/ngga_conv_pipe.sv @@
// ngga_conv_pipe: six-stage elastic pipeline turning raw positions into
// degrees and billionths of a degree, with its own valid bits and stall chain
// depends on ngga_pkg

module ngga_conv_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  ngga_pkg::raw_fix_t in_fix,
  output logic               in_ready,
  input  logic               out_stall,
  output logic               out_valid,
  output ngga_pkg::result_t  out_res
);

  localparam int Stages = 6;

  // one coordinate as it travels down the pipeline
  typedef struct packed {
    logic [16:0] ipart;
    logic [16:0] f5;
    logic [7:0]  hemi;
    logic [9:0]  deg;
    logic [6:0]  mins;
    logic [29:0] t;
    logic [29:0] q3;
    logic [30:0] bill;
  } coord_t;

  typedef struct packed {
    logic       fix_valid;
    logic [7:0] fix_quality;
    coord_t     lat;
    coord_t     lon;
  } stage_t;

  stage_t            st_r [Stages];
  stage_t            st_nxt [Stages];
  logic [Stages-1:0] v_r;
  logic [Stages-1:0] rdy;

  // integer part / 100 by reciprocal, exact below 199728
  function automatic logic [9:0] deg_of(input logic [16:0] x);
    logic [34:0] p;
    p = x * 18'd167773;
    return p[33:24];
  endfunction

  // integer part mod 100
  function automatic logic [6:0] mins_of(input logic [16:0] x, input logic [9:0] q);
    logic [16:0] m;
    m = x - 17'(q) * 17'd100;
    return m[6:0];
  endfunction

  // minutes scaled to 1e-7 plus the fraction scaled to match
  function automatic logic [29:0] t_of(input logic [6:0] m, input logic [16:0] f);
    logic [30:0] s;
    s = 31'(m) * 31'd10000000 + 31'(f) * 31'd100;
    return s[29:0];
  endfunction

  // t / 3 by reciprocal, exact below 2^31
  function automatic logic [29:0] third_of(input logic [29:0] t);
    logic [61:0] p;
    p = t * 31'd1431655766;
    return p[61:32];
  endfunction

  // floor((5t + 1) / 3) = 5q + floor((5r + 1) / 3) with t = 3q + r
  function automatic logic [30:0] bill_of(input logic [29:0] t, input logic [29:0] q);
    logic [29:0] r;
    logic [1:0]  inc;
    r = t - 30'(q * 2'd3);
    unique case (r[1:0])
      2'd0:    inc = 2'd0;
      2'd1:    inc = 2'd2;
      default: inc = 2'd3;
    endcase
    return 31'(q) * 31'd5 + 31'(inc);
  endfunction

  // stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[Stages-1] = !v_r[Stages-1] || !out_stall;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // per-stage arithmetic
  always_comb begin
    st_nxt[0]                 = '0;
    st_nxt[0].fix_valid       = in_fix.fix_valid;
    st_nxt[0].fix_quality     = in_fix.fix_quality;
    st_nxt[0].lat.ipart       = 17'(in_fix.pos.lat_ipart);
    st_nxt[0].lat.f5          = in_fix.pos.lat_f5;
    st_nxt[0].lat.hemi        = in_fix.pos.lat_hemi;
    st_nxt[0].lon.ipart       = in_fix.pos.lon_ipart;
    st_nxt[0].lon.f5          = in_fix.pos.lon_f5;
    st_nxt[0].lon.hemi        = in_fix.pos.lon_hemi;

    st_nxt[1]                 = st_r[0];
    st_nxt[1].lat.deg         = deg_of(st_r[0].lat.ipart);
    st_nxt[1].lon.deg         = deg_of(st_r[0].lon.ipart);

    st_nxt[2]                 = st_r[1];
    st_nxt[2].lat.mins        = mins_of(st_r[1].lat.ipart, st_r[1].lat.deg);
    st_nxt[2].lon.mins        = mins_of(st_r[1].lon.ipart, st_r[1].lon.deg);

    st_nxt[3]                 = st_r[2];
    st_nxt[3].lat.t           = t_of(st_r[2].lat.mins, st_r[2].lat.f5);
    st_nxt[3].lon.t           = t_of(st_r[2].lon.mins, st_r[2].lon.f5);

    st_nxt[4]                 = st_r[3];
    st_nxt[4].lat.q3          = third_of(st_r[3].lat.t);
    st_nxt[4].lon.q3          = third_of(st_r[3].lon.t);

    st_nxt[5]                 = st_r[4];
    st_nxt[5].lat.bill        = bill_of(st_r[4].lat.t, st_r[4].lat.q3);
    st_nxt[5].lon.bill        = bill_of(st_r[4].lon.t, st_r[4].lon.q3);
  end

  // stage payload, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < Stages; k++) begin
      if (rdy[k]) st_r[k] <= st_nxt[k];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_fire;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // result beat from the last stage
  assign out_valid = v_r[Stages-1];
  always_comb begin
    out_res.fix_valid      = st_r[Stages-1].fix_valid;
    out_res.fix_quality    = st_r[Stages-1].fix_quality;
    out_res.lat_degrees    = st_r[Stages-1].lat.deg[6:0];
    out_res.lat_billionths = st_r[Stages-1].lat.bill;
    out_res.lat_hemisphere = st_r[Stages-1].lat.hemi;
    out_res.lon_degrees    = st_r[Stages-1].lon.deg;
    out_res.lon_billionths = st_r[Stages-1].lon.bill;
    out_res.lon_hemisphere = st_r[Stages-1].lon.hemi;
  end

endmodule

@@ design/ngga_checker.sv @@
// ngga_checker: port-level assertions for the GGA position parser
// bound to nmea_gga_position_parser_unit; depends on ngga_pkg

module ngga_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_fix_valid,
  input logic [7:0]  out_fix_quality,
  input logic [6:0]  out_lat_degrees,
  input logic [30:0] out_lat_billionths,
  input logic [7:0]  out_lat_hemisphere,
  input logic [9:0]  out_lon_degrees,
  input logic [30:0] out_lon_billionths,
  input logic [7:0]  out_lon_hemisphere
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fix_valid) &&
      $stable(out_fix_quality) && $stable(out_lat_billionths) &&
      $stable(out_lon_billionths) && $stable(out_lat_degrees) &&
      $stable(out_lon_degrees) && $stable(out_lat_hemisphere) &&
      $stable(out_lon_hemisphere))
    else $error("stalled result beat changed");

  // input only backs up when a result is waiting on the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no result waiting");

  // a valid fix carries a quality of 1, 2 or 6
  a_quality: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_valid |-> (out_fix_quality == ngga_pkg::CH_ONE) ||
      (out_fix_quality == ngga_pkg::CH_TWO) || (out_fix_quality == ngga_pkg::CH_SIX))
    else $error("valid fix with a bad quality character");

  // converted values stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lat_degrees <= 7'd99) &&
      (out_lat_billionths <= ngga_pkg::BILL_MAX) &&
      (out_lon_billionths <= ngga_pkg::BILL_MAX))
    else $error("converted position out of range");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

endmodule

bind nmea_gga_position_parser_unit ngga_checker u_ngga_checker (.*);

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for nmea_gga_position_parser_unit
// feeds directed and random NMEA character streams and checks every fix beat
// depends on ngga_pkg and the parser unit
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [3:0] {
    SCAN_TAG, SCAN_HEAD, SKIP_TIME, READ_LAT, READ_NS, READ_LON, READ_EW, READ_FIX
  } gga_phase_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AFTER  = 350;
  localparam int HOLD_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_fix_valid;
  logic [7:0]  out_fix_quality;
  logic [6:0]  out_lat_degrees;
  logic [30:0] out_lat_billionths;
  logic [7:0]  out_lat_hemisphere;
  logic [9:0]  out_lon_degrees;
  logic [30:0] out_lon_billionths;
  logic [7:0]  out_lon_hemisphere;

  nmea_gga_position_parser_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_ch              (in_ch),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fix_valid      (out_fix_valid),
    .out_fix_quality    (out_fix_quality),
    .out_lat_degrees    (out_lat_degrees),
    .out_lat_billionths (out_lat_billionths),
    .out_lat_hemisphere (out_lat_hemisphere),
    .out_lon_degrees    (out_lon_degrees),
    .out_lon_billionths (out_lon_billionths),
    .out_lon_hemisphere (out_lon_hemisphere)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  logic [7:0]         pending_chars[$];
  logic [7:0]         draft[$];
  ngga_pkg::result_t  expected_fixes[$];
  int                 mismatches = 0;
  int                 taken_chars = 0;
  int                 cycles = 0;
  logic               in_taken = 1'b0;

  // parser mirror state
  gga_phase_t         phase = SCAN_TAG;
  logic [1:0]         g_run = '0;
  logic [16:0]        int_acc = '0;
  logic [16:0]        frac_acc = '0;
  logic [2:0]         int_n = '0;
  logic [2:0]         frac_n = '0;
  logic               dot_seen = 1'b0;
  logic [7:0]         last_ch = '0;
  ngga_pkg::result_t  work_pos = '0;
  ngga_pkg::result_t  held_pos = '0;

  task clear_number();
    int_acc  = '0;
    frac_acc = '0;
    int_n    = '0;
    frac_n   = '0;
    dot_seen = 1'b0;
  endtask

  // one character of a number field: digits, point, anything else dropped
  task number_char(input logic [7:0] c, input logic [2:0] lim);
    logic [16:0] d;
    d = 17'(c - ngga_pkg::CH_ZERO);
    if (c == ngga_pkg::CH_POINT) begin
      dot_seen = 1'b1;
    end else if (c >= ngga_pkg::CH_ZERO && c <= ngga_pkg::CH_NINE) begin
      if (!dot_seen) begin
        if (int_n < lim) begin
          int_acc = int_acc * 17'd10 + d;
          int_n++;
        end
      end else if (frac_n < ngga_pkg::FRAC_DIGITS) begin
        frac_acc = frac_acc * 17'd10 + d;
        frac_n++;
      end
    end
  endtask

  // minutes and five-digit fraction to billionths of a degree, rounded as (5t+1)/3
  function automatic logic [30:0] to_billionths();
    logic [63:0] f5, t;
    f5 = 64'(frac_acc);
    for (int k = int'(frac_n); k < 5; k++) f5 = f5 * 64'd10;
    t = 64'(int_acc % 17'd100) * 64'd10000000 + f5 * 64'd100;
    return 31'((64'd5 * t + 64'd1) / 64'd3);
  endfunction

  // advance the parser mirror by one accepted character
  task gga_track(input logic [7:0] c);
    logic              good;
    ngga_pkg::result_t fix;
    if (c == ngga_pkg::CH_DOLLAR) begin
      phase = SCAN_TAG;
      g_run = '0;
      clear_number();
      last_ch = c;
      return;
    end
    case (phase)
      SCAN_TAG: begin
        if (c == ngga_pkg::CH_G) g_run = (g_run >= 2'd1) ? 2'd2 : 2'd1;
        else if (c == ngga_pkg::CH_A && g_run == 2'd2) begin
          g_run = '0;
          phase = SCAN_HEAD;
        end else g_run = '0;
      end
      SCAN_HEAD: if (c == ngga_pkg::CH_COMMA) phase = SKIP_TIME;
      SKIP_TIME: begin
        if (c == ngga_pkg::CH_COMMA) begin
          clear_number();
          phase = READ_LAT;
        end
      end
      READ_LAT: begin
        if (c == ngga_pkg::CH_COMMA) begin
          work_pos.lat_degrees    = 7'(int_acc / 17'd100);
          work_pos.lat_billionths = to_billionths();
          clear_number();
          phase = READ_NS;
        end else number_char(c, ngga_pkg::LAT_INT_DIGITS);
      end
      READ_NS: begin
        if (last_ch == ngga_pkg::CH_COMMA) work_pos.lat_hemisphere = c;
        if (c == ngga_pkg::CH_COMMA) begin
          clear_number();
          phase = READ_LON;
        end
      end
      READ_LON: begin
        if (c == ngga_pkg::CH_COMMA) begin
          work_pos.lon_degrees    = 10'(int_acc / 17'd100);
          work_pos.lon_billionths = to_billionths();
          clear_number();
          phase = READ_EW;
        end else number_char(c, ngga_pkg::LON_INT_DIGITS);
      end
      READ_EW: begin
        if (last_ch == ngga_pkg::CH_COMMA) work_pos.lon_hemisphere = c;
        // the point flag doubles as the e/w-present flag here
        if (c == ngga_pkg::CH_COMMA) begin
          dot_seen = (last_ch == ngga_pkg::CH_E || last_ch == ngga_pkg::CH_W);
          phase = READ_FIX;
        end
      end
      default: begin
        good = (c == ngga_pkg::CH_ONE || c == ngga_pkg::CH_TWO ||
                c == ngga_pkg::CH_SIX) && dot_seen;
        if (good) held_pos = work_pos;
        fix = held_pos;
        fix.fix_valid   = good;
        fix.fix_quality = c;
        expected_fixes.push_back(fix);
        clear_number();
        g_run = '0;
        phase = SCAN_TAG;
      end
    endcase
    last_ch = c;
  endtask

  // idle length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task check_field(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    end
  endtask

  // stimulus building
  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // random number field, sometimes too long, too short or with junk in it
  task add_num(input int ndig);
    int style, n_int, n_fr;
    bit dot;
    style = $urandom_range(0, 9);
    n_int = $urandom_range(0, ndig + 2);
    n_fr  = $urandom_range(0, 7);
    dot   = ($urandom_range(0, 9) != 0);
    if (style < 2) begin
      n_int = ndig + 1;
      n_fr  = 6;
      dot   = 1'b1;
    end
    for (int i = 0; i < n_int; i++) begin
      draft.push_back(style == 0 ? ngga_pkg::CH_NINE :
                      style == 1 ? ngga_pkg::CH_ZERO : rand_digit());
      if ($urandom_range(0, 39) == 0) draft.push_back(8'($urandom_range(8'h3A, 8'h7E)));
    end
    if (dot) draft.push_back(ngga_pkg::CH_POINT);
    for (int i = 0; i < n_fr; i++) begin
      draft.push_back(style == 0 ? ngga_pkg::CH_NINE :
                      style == 1 ? ngga_pkg::CH_ZERO : rand_digit());
      if ($urandom_range(0, 49) == 0) draft.push_back(ngga_pkg::CH_POINT);
    end
  endtask

  // hemisphere field: usually the proper letter, sometimes empty or odd
  task add_hemi(input string pair);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) draft.push_back(pair[$urandom_range(0, 1)]);
    else if (r == 9) begin
      draft.push_back(8'($urandom_range(8'h41, 8'h5A)));
      draft.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end
  endtask

  task queue_sentence();
    int r, cut;
    string talker, good_q, bad_q;
    talker = "PNL";
    good_q = "126";
    bad_q  = "0345789";
    r = $urandom_range(0, 99);
    if (r < 6) add_text("$GGGA");
    else if (r < 10) add_text("$GPGSA");
    else if (r < 13) add_text("GGA");
    else begin
      add_text("$G");
      draft.push_back(talker[$urandom_range(0, 2)]);
      add_text("GGA");
    end
    add_text(",");
    add_num(6);
    add_text(",");
    add_num(4);
    add_text(",");
    add_hemi("NS");
    add_text(",");
    add_num(5);
    add_text(",");
    add_hemi("EW");
    add_text(",");
    r = $urandom_range(0, 99);
    if (r < 60) draft.push_back(good_q[$urandom_range(0, 2)]);
    else if (r < 85) draft.push_back(bad_q[$urandom_range(0, 6)]);
    else if (r < 92) draft.push_back(ngga_pkg::CH_COMMA);
    else if (r < 97) draft.push_back(8'($urandom_range(0, 255)));
    else draft.push_back(ngga_pkg::CH_DOLLAR);
    add_text(",08,*5C");
    draft.push_back(8'h0D);
    draft.push_back(8'h0A);
    // broken sentence: cut short somewhere
    if ($urandom_range(0, 99) < 8) begin
      cut = $urandom_range(1, draft.size() - 1);
      while (draft.size() > cut) void'(draft.pop_back());
    end
    while (draft.size() > 0) pending_chars.push_back(draft.pop_front());
  endtask

  // driver: new beat at the falling edge once the previous one is taken
  int tx_gap = 0;
  int tx_calm = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled beat keeps its payload
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (pending_chars.size() > 0) begin
      in_valid <= 1'b1;
      in_ch    <= pending_chars.pop_front();
      if (tx_calm > 0) begin
        tx_calm--;
        tx_gap = 0;
      end else begin
        tx_gap = gap_len();
        if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(40, 160);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with one long hold-off to fill the block
  int  rx_gap = 0;
  int  rx_calm = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && taken_chars >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
      if (rx_calm > 0) rx_calm--;
      else begin
        rx_gap = gap_len();
        if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(40, 160);
      end
    end
  end

  // monitor: track accepted characters, then check result beats
  always @(posedge clk) begin : watch
    ngga_pkg::result_t want;
    if (rst_n && in_valid && !in_stall) begin
      gga_track(in_ch);
      taken_chars++;
    end
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fixes.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, fix_quality expected none got %0d",
                 $time, out_fix_quality);
      end else begin
        want = expected_fixes.pop_front();
        check_field("fix_valid", 32'(want.fix_valid), 32'(out_fix_valid));
        check_field("fix_quality", 32'(want.fix_quality), 32'(out_fix_quality));
        check_field("lat_degrees", 32'(want.lat_degrees), 32'(out_lat_degrees));
        check_field("lat_billionths", 32'(want.lat_billionths), 32'(out_lat_billionths));
        check_field("lat_hemisphere", 32'(want.lat_hemisphere), 32'(out_lat_hemisphere));
        check_field("lon_degrees", 32'(want.lon_degrees), 32'(out_lon_degrees));
        check_field("lon_billionths", 32'(want.lon_billionths), 32'(out_lon_billionths));
        check_field("lon_hemisphere", 32'(want.lon_hemisphere), 32'(out_lon_hemisphere));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("nmea_gga_position_parser_unit: mismatch");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stim
    int sentences;
    sentences = 0;
    // extremes, repeated g, excess and missing digits
    add_text("$GGGA,235959.99,9999.999999,S,999999.99,W,6*");
    add_text("$GPGGA,,0000.00000,N,00000.00000,E,1,");
    add_text("$GPGGA,1,12.5,N,,E,2");
    // junk and a second point in numbers, empty n/s, comma as fix character
    add_text("$GPGGA,,4x7.1.2,,1A3,W,,");
    // empty e/w, dollar on the fix position
    add_text("$GPGGA,,12,N,3,,1");
    add_text("$GPGGA,,12,N,3,E,$");
    // e/w judged on its last character, minutes above 59
    add_text("$GPGGA,,1,N,2,EW,2");
    add_text("$GPGGA,,1,N,2,WX,1");
    add_text("$GPGGA,,8975.5,N,18099.25,E,6");
    // dollar inside the tag
    add_text("$GPG$GGA,,1,S,1,W,2");
    draft.push_back(8'h00);
    draft.push_back(8'hFF);
    draft.push_back(8'h80);
    draft.push_back(8'h7F);
    while (draft.size() > 0) pending_chars.push_back(draft.pop_front());

    // random sentences with some line noise between them
    while (pending_chars.size() < 900 || sentences < 48) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) pending_chars.push_back(8'($urandom_range(0, 255)));
      end
      queue_sentence();
      sentences++;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_fixes.size() == 0) begin
      $display("nmea_gga_position_parser_unit: match");
    end else begin
      $display("nmea_gga_position_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ngga_pkg.sv
design/ngga_parser.sv
design/ngga_conv_pipe.sv
design/nmea_gga_position_parser_unit.sv
design/ngga_checker.sv
sim/tb_top.sv
